// ===== hdl/clh_pkg.sv =====
// Package for the console line editor with history.
// Holds key codes, escape phases, sequencer states and parameter defaults.
// No dependencies.
`default_nettype none

package clh_pkg;

   localparam int LINE_BYTES_DEF    = 64;
   localparam int HISTORY_LINES_DEF = 4;

   // console key codes
   localparam logic [7:0] KEY_NUL     = 8'h00;
   localparam logic [7:0] KEY_ESC     = 8'h1b;
   localparam logic [7:0] KEY_BRACKET = 8'h5b;
   localparam logic [7:0] KEY_UP      = 8'h41;
   localparam logic [7:0] KEY_DOWN    = 8'h42;
   localparam logic [7:0] KEY_RIGHT   = 8'h43;
   localparam logic [7:0] KEY_LEFT    = 8'h44;
   localparam logic [7:0] KEY_DEL     = 8'h7f;
   localparam logic [7:0] KEY_BS      = 8'h08;
   localparam logic [7:0] KEY_CR      = 8'h0d;
   localparam logic [7:0] KEY_LF      = 8'h0a;

   // escape sequence phase
   localparam logic [1:0] PH_NORMAL = 2'd0;
   localparam logic [1:0] PH_ESC    = 2'd1;
   localparam logic [1:0] PH_CSI    = 2'd2;

   typedef enum logic [3:0] {
      ST_CLEAR_ALL,
      ST_IDLE,
      ST_RECALL,
      ST_CHECK,
      ST_SHIFT,
      ST_STORE,
      ST_EMIT_RD,
      ST_EMIT_LD,
      ST_EMIT_WAIT,
      ST_CLEAR_LINE
   } state_type;

endpackage

`default_nettype wire

// ===== hdl/console_line_editor_history.sv =====
// Console line editor with deduplicated command history: top level.
// Line buffer and history live in two registered-read RAMs walked by a sequencer.
// Depends on clh_pkg.
//
//  channel | dir | handshake          | payload
//  req     | in  | req_tvalid/tready  | tdata[7:0] rx_byte
//  rsp     | out | rsp_tvalid/tready  | tdata[7:0] line_byte, tlast last_of_line
//
// Edit bytes, escapes and cursor moves are handled in the idle state. A recall copies
// one history entry into the line. CR/LF checks the line, compares it with the newest
// entry and, if the line is new, shifts the history toward the oldest when it is full
// and stores the line; it then emits the line byte by byte with rsp stalls and clears
// it. After reset a clearing pass over the history runs before the first request is taken.
`default_nettype none

module console_line_editor_history
   import clh_pkg::*;
#(
   parameter int LINE_BYTES    = LINE_BYTES_DEF,
   parameter int HISTORY_LINES = HISTORY_LINES_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] rx_byte
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] line_byte
   output logic            rsp_tlast    // last_of_line
);

   localparam int HIST_BYTES = HISTORY_LINES * LINE_BYTES;
   localparam int LAW  = $clog2(LINE_BYTES);
   localparam int HAW  = $clog2(HIST_BYTES);
   localparam int CW   = $clog2(LINE_BYTES + 1);
   localparam int HPW  = $clog2(HISTORY_LINES + 1);
   localparam int CNTW = $clog2(HIST_BYTES + 1);
   localparam logic [HAW-1:0]  LB_H     = HAW'(LINE_BYTES);
   localparam logic [CW-1:0]   LB_C     = CW'(LINE_BYTES);
   localparam logic [CNTW-1:0] LB_N     = CNTW'(LINE_BYTES);
   localparam logic [CNTW-1:0] SHIFT_N  = CNTW'((HISTORY_LINES - 1) * LINE_BYTES);
   localparam logic [CNTW-1:0] ALL_LAST = CNTW'(HIST_BYTES - 1);
   localparam logic [CNTW-1:0] LB_LAST  = CNTW'(LINE_BYTES - 1);
   localparam logic [HPW-1:0]  HL_P     = HPW'(HISTORY_LINES);

   // memories
   logic [7:0] line_mem [LINE_BYTES];
   logic [7:0] hist_mem [HIST_BYTES];

   state_type       state_ff, state_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic            pvld_ff, pvld_in;
   logic [CNTW-1:0] pcnt_ff;
   logic [7:0]      byte_ff, byte_in;
   logic [CW-1:0]   cursor_ff, cursor_in;
   logic [CW-1:0]   extent_ff, extent_in;
   logic [1:0]      phase_ff, phase_in;
   logic [HPW-1:0]  used_ff, used_in;
   logic [HPW-1:0]  ptr_ff, ptr_in;
   logic [HPW-1:0]  src_ff, src_in;
   logic            ok_ff, ok_in;
   logic            eq_ff, eq_in;
   logic            found_ff, found_in;
   logic [CW-1:0]   len_ff, len_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [7:0]      rsp_data_ff, rsp_data_in;
   logic            rsp_last_ff, rsp_last_in;

   logic            lm_we, hm_we;
   logic [LAW-1:0]  lm_raddr, lm_waddr;
   logic [HAW-1:0]  hm_raddr, hm_waddr;
   logic [7:0]      lm_wdata, hm_wdata, lm_rdata_ff, hm_rdata_ff;

   logic [CNTW-1:0] pass_n;
   logic            issue, pass_done, take;
   logic [HPW-1:0]  cmp_idx, down_idx;
   logic            full, push, csr_ok;
   logic [CW-1:0]   cur_m1;

   // shared flags
   always_comb begin
      case (state_ff)
         ST_RECALL, ST_CHECK, ST_STORE: pass_n = LB_N;
         ST_SHIFT:                      pass_n = SHIFT_N;
         default:                       pass_n = '0;
      endcase
      issue     = (cnt_ff < pass_n);
      pass_done = !issue && !pvld_ff;
      take      = (state_ff == ST_IDLE) && req_tvalid;
      full      = (used_ff == HL_P);
      cmp_idx   = full ? HPW'(HISTORY_LINES - 1) : used_ff - HPW'(1);
      push      = (used_ff == '0) || !eq_ff;
      down_idx  = ((HPW+1)'(ptr_ff) + (HPW+1)'(1) < (HPW+1)'(used_ff))
                  ? ptr_ff + HPW'(1) : used_ff - HPW'(1);
      csr_ok    = (cursor_ff != '0) && (cursor_ff < LB_C);
      cur_m1    = cursor_ff - CW'(1);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR_ALL: begin
            if (cnt_ff == ALL_LAST) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (take && req_tdata != KEY_NUL && req_tdata != KEY_ESC) begin
               if (phase_ff == PH_CSI) begin
                  if (req_tdata == KEY_UP && ptr_ff != '0) state_in = ST_RECALL;
                  if (req_tdata == KEY_DOWN && used_ff != '0) state_in = ST_RECALL;
               end else if (!(phase_ff == PH_ESC && req_tdata == KEY_BRACKET) &&
                            (req_tdata == KEY_CR || req_tdata == KEY_LF)) begin
                  state_in = csr_ok ? ST_CHECK : ST_CLEAR_LINE;
               end
            end
         end
         ST_RECALL: begin
            if (pass_done) state_in = ST_IDLE;
         end
         ST_CHECK: begin
            if (pass_done) begin
               if (!ok_ff)     state_in = ST_CLEAR_LINE;
               else if (!push) state_in = ST_EMIT_RD;
               else if (full)  state_in = ST_SHIFT;
               else            state_in = ST_STORE;
            end
         end
         ST_SHIFT: begin
            if (pass_done) state_in = ST_STORE;
         end
         ST_STORE: begin
            if (pass_done) state_in = ST_EMIT_RD;
         end
         ST_EMIT_RD: state_in = ST_EMIT_LD;
         ST_EMIT_LD: state_in = ST_EMIT_WAIT;
         ST_EMIT_WAIT: begin
            if (rsp_tready) state_in = rsp_last_ff ? ST_CLEAR_LINE : ST_EMIT_RD;
         end
         ST_CLEAR_LINE: begin
            if (cnt_ff == LB_LAST) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      cnt_in       = cnt_ff;
      pvld_in      = 1'b0;
      byte_in      = byte_ff;
      cursor_in    = cursor_ff;
      extent_in    = extent_ff;
      phase_in     = phase_ff;
      used_in      = used_ff;
      ptr_in       = ptr_ff;
      src_in       = src_ff;
      ok_in        = ok_ff;
      eq_in        = eq_ff;
      found_in     = found_ff;
      len_in       = len_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      lm_we        = 1'b0;
      hm_we        = 1'b0;
      lm_waddr     = pcnt_ff[LAW-1:0];
      hm_waddr     = HAW'(pcnt_ff);
      lm_wdata     = '0;
      hm_wdata     = '0;
      lm_raddr     = cnt_ff[LAW-1:0];
      hm_raddr     = HAW'(src_ff) * LB_H + HAW'(cnt_ff);

      unique case (state_ff)
         ST_CLEAR_ALL: begin
            hm_we    = 1'b1;
            hm_waddr = HAW'(cnt_ff);
            lm_we    = (cnt_ff < LB_N);
            lm_waddr = cnt_ff[LAW-1:0];
            cnt_in   = cnt_ff + CNTW'(1);
         end
         ST_IDLE: begin
            cnt_in   = '0;
            ok_in    = 1'b1;
            eq_in    = 1'b1;
            found_in = 1'b0;
            len_in   = LB_C;
            if (take && req_tdata != KEY_NUL) begin
               if (req_tdata == KEY_ESC) begin
                  phase_in = PH_ESC;
               end else if (phase_ff == PH_ESC && req_tdata == KEY_BRACKET) begin
                  phase_in = PH_CSI;
               end else if (phase_ff == PH_CSI) begin
                  phase_in = PH_NORMAL;
                  unique case (req_tdata)
                     KEY_UP: begin
                        if (ptr_ff != '0) begin
                           ptr_in = ptr_ff - HPW'(1);
                           src_in = ptr_ff - HPW'(1);
                        end
                     end
                     KEY_DOWN: begin
                        if (used_ff != '0) begin
                           ptr_in = down_idx;
                           src_in = down_idx;
                        end
                     end
                     KEY_RIGHT: begin
                        if (cursor_ff < extent_ff) cursor_in = cursor_ff + CW'(1);
                     end
                     KEY_LEFT: begin
                        if (cursor_ff != '0) cursor_in = cur_m1;
                     end
                     default: ;
                  endcase
               end else begin
                  phase_in = PH_NORMAL;
                  if (req_tdata == KEY_CR || req_tdata == KEY_LF) begin
                     byte_in = req_tdata;
                  end else if (req_tdata == KEY_DEL || req_tdata == KEY_BS) begin
                     if (cursor_ff != '0) begin
                        cursor_in = cur_m1;
                        extent_in = cur_m1;
                        lm_we     = 1'b1;
                        lm_waddr  = cur_m1[LAW-1:0];
                     end
                  end else if (cursor_ff < LB_C - CW'(1)) begin
                     lm_we     = 1'b1;
                     lm_waddr  = cursor_ff[LAW-1:0];
                     lm_wdata  = req_tdata;
                     cursor_in = cursor_ff + CW'(1);
                     extent_in = cursor_ff + CW'(1);
                  end else begin
                     cursor_in = '0;
                     extent_in = '0;
                  end
               end
            end
         end
         ST_RECALL: begin
            // copy entry into line, find terminated length
            if (issue) begin
               pvld_in = 1'b1;
               cnt_in  = cnt_ff + CNTW'(1);
            end
            if (pvld_ff) begin
               lm_we    = 1'b1;
               lm_wdata = hm_rdata_ff;
               if (!found_ff && hm_rdata_ff == 8'h00) begin
                  found_in = 1'b1;
                  len_in   = CW'(pcnt_ff);
               end
            end
            if (pass_done) begin
               cursor_in = len_ff;
               extent_in = len_ff;
            end
         end
         ST_CHECK: begin
            // terminator check and compare against newest entry in one scan
            hm_raddr = HAW'(cmp_idx) * LB_H + HAW'(cnt_ff);
            if (issue) begin
               pvld_in = 1'b1;
               cnt_in  = cnt_ff + CNTW'(1);
            end
            if (pvld_ff) begin
               if (pcnt_ff < CNTW'(cursor_ff) && lm_rdata_ff == 8'h00) ok_in = 1'b0;
               if (pcnt_ff == CNTW'(cursor_ff) && lm_rdata_ff != 8'h00) ok_in = 1'b0;
               if (lm_rdata_ff != hm_rdata_ff) eq_in = 1'b0;
            end
            if (pass_done) begin
               cnt_in = '0;
               if (ok_ff) begin
                  ptr_in = used_ff;
                  if (push && full) begin
                     src_in = HPW'(HISTORY_LINES - 1);
                  end else if (push) begin
                     src_in  = used_ff;
                     used_in = used_ff + HPW'(1);
                     ptr_in  = used_ff + HPW'(1);
                  end
               end
            end
         end
         ST_SHIFT: begin
            // move every entry but the oldest one slot toward the oldest
            hm_raddr = HAW'(cnt_ff) + LB_H;
            if (issue) begin
               pvld_in = 1'b1;
               cnt_in  = cnt_ff + CNTW'(1);
            end
            if (pvld_ff) begin
               hm_we    = 1'b1;
               hm_wdata = hm_rdata_ff;
            end
            if (pass_done) cnt_in = '0;
         end
         ST_STORE: begin
            if (issue) begin
               pvld_in = 1'b1;
               cnt_in  = cnt_ff + CNTW'(1);
            end
            if (pvld_ff) begin
               hm_we    = 1'b1;
               hm_waddr = HAW'(src_ff) * LB_H + HAW'(pcnt_ff);
               hm_wdata = (pcnt_ff < CNTW'(cursor_ff)) ? lm_rdata_ff : 8'h00;
            end
            if (pass_done) cnt_in = '0;
         end
         ST_EMIT_RD: ;
         ST_EMIT_LD: begin
            rsp_valid_in = 1'b1;
            rsp_last_in  = (cnt_ff == CNTW'(cursor_ff));
            rsp_data_in  = rsp_last_in ? byte_ff : lm_rdata_ff;
         end
         ST_EMIT_WAIT: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               cnt_in       = rsp_last_ff ? '0 : cnt_ff + CNTW'(1);
            end
         end
         ST_CLEAR_LINE: begin
            lm_we    = 1'b1;
            lm_waddr = cnt_ff[LAW-1:0];
            cnt_in   = cnt_ff + CNTW'(1);
            if (cnt_ff == LB_LAST) cursor_in = '0;
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR_ALL;
         cnt_ff       <= '0;
         pvld_ff      <= 1'b0;
         cursor_ff    <= '0;
         extent_ff    <= '0;
         phase_ff     <= PH_NORMAL;
         used_ff      <= '0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pvld_ff      <= pvld_in;
         cursor_ff    <= cursor_in;
         extent_ff    <= extent_in;
         phase_ff     <= phase_in;
         used_ff      <= used_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pcnt_ff     <= cnt_ff;
      byte_ff     <= byte_in;
      src_ff      <= src_in;
      ok_ff       <= ok_in;
      eq_ff       <= eq_in;
      found_ff    <= found_in;
      len_ff      <= len_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   // line RAM
   always_ff @(posedge clock) begin
      if (lm_we) line_mem[lm_waddr] <= lm_wdata;
      lm_rdata_ff <= line_mem[lm_raddr];
   end

   // history RAM
   always_ff @(posedge clock) begin
      if (hm_we) hist_mem[hm_waddr] <= hm_wdata;
      hm_rdata_ff <= hist_mem[hm_raddr];
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire
